// ===== src/hcbd_pkg.sv =====
package hcbd_pkg;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;

    // Width of one hex digit of the chunk size
    localparam int HEX_DIGIT_BITS = 4;

    typedef enum logic [5:0] {
        PH_LINE_START = 6'b000001,
        PH_DIGITS     = 6'b000010,
        PH_EXTENSION  = 6'b000100,
        PH_DATA       = 6'b001000,
        PH_AFTER_DATA = 6'b010000,
        PH_SKIP_ONE   = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        ST_ZERO_CHUNK = 2'd0,
        ST_IN_SIZE    = 2'd1,
        ST_IN_DATA    = 2'd2
    } t_end_status;

    typedef struct packed {
        logic                      is_digit;
        logic [HEX_DIGIT_BITS-1:0] value;
    } t_hex;

    // Decode one ASCII hex digit, either case
    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.is_digit = 1'b1;
        h.value    = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = HEX_DIGIT_BITS'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = HEX_DIGIT_BITS'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = HEX_DIGIT_BITS'(c - 8'h37);
        end else begin
            h.is_digit = 1'b0;
        end
        return h;
    endfunction

endpackage

// ===== src/http_chunked_body_decoder.sv =====
// Chunked body decoder: takes one body byte per transfer and returns the chunk data bytes
// with the size lines, extensions and CR LF framing removed. One byte is accepted every
// cycle unless the output stalls; each accepted byte passes through an input register and
// then a result register, with a single pass of decode logic between them. Framing bytes
// produce no result. The transfer that closes a message carries message_end, with
// end_status telling a zero chunk from a body cut short inside a size line or inside/after
// data. Bytes after a zero chunk are dropped up to and including the byte marked last,
// after which the decoder is ready for the next message. Chunk sizes wider than SIZE_BITS
// saturate to all ones.
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_body_byte,
    input  logic       i_body_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_data_byte,
    output logic       o_data_valid,
    output logic       o_message_end,
    output logic [1:0] o_end_status
);

    localparam int HB = hcbd_pkg::HEX_DIGIT_BITS;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Decoder state
    hcbd_pkg::t_phase     r_phase, n_phase;
    logic [SIZE_BITS-1:0] r_bytes_left, n_bytes_left;
    logic                 r_saw_cr, n_saw_cr;
    logic                 r_closed, n_closed;

    // Result register
    logic                    r_out_valid;
    logic [7:0]              r_out_byte;
    logic                    r_out_dvalid;
    logic                    r_out_end;
    hcbd_pkg::t_end_status   r_out_status;

    logic                    advance;
    logic                    res_valid;
    logic [7:0]              res_byte;
    logic                    res_dvalid;
    logic                    res_end;
    hcbd_pkg::t_end_status   res_status;

    hcbd_pkg::t_hex          hex;
    logic                    sl_sat;
    logic [SIZE_BITS-1:0]    sl_bytes;
    logic                    sl_size_zero;
    logic [SIZE_BITS-1:0]    dec_bytes;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign hex          = hcbd_pkg::hex_value(r_in_byte);
    assign sl_sat       = |r_bytes_left[SIZE_BITS-1 -: HB];
    assign sl_bytes     = sl_sat ? '1 : {r_bytes_left[SIZE_BITS-HB-1:0], hex.value};
    assign sl_size_zero = (r_bytes_left == '0);
    assign dec_bytes    = r_bytes_left - SIZE_BITS'(1);

    always_comb begin
        logic closes;
        logic size_line;
        closes       = 1'b0;
        size_line    = 1'b0;
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_saw_cr     = r_saw_cr;
        n_closed     = r_closed;
        res_byte     = '0;
        res_dvalid   = 1'b0;
        res_end      = 1'b0;
        res_status   = hcbd_pkg::ST_ZERO_CHUNK;

        if (r_closed) begin
            // Drop until the last byte of the message
            if (r_in_last) begin
                n_phase      = hcbd_pkg::PH_LINE_START;
                n_bytes_left = '0;
                n_saw_cr     = 1'b0;
                n_closed     = 1'b0;
            end
        end else begin
            unique case (r_phase)
                hcbd_pkg::PH_LINE_START, hcbd_pkg::PH_DIGITS: begin
                    size_line = 1'b1;
                end
                hcbd_pkg::PH_EXTENSION: begin
                    if (r_in_byte == hcbd_pkg::CH_LF && r_saw_cr) begin
                        n_saw_cr = 1'b0;
                        n_phase  = hcbd_pkg::PH_DATA;
                    end else begin
                        n_saw_cr = (r_in_byte == hcbd_pkg::CH_CR);
                    end
                end
                hcbd_pkg::PH_DATA: begin
                    res_byte   = r_in_byte;
                    res_dvalid = 1'b1;
                    if (!sl_size_zero) begin
                        n_bytes_left = dec_bytes;
                    end
                    if (sl_size_zero || dec_bytes == '0) begin
                        n_phase = hcbd_pkg::PH_AFTER_DATA;
                    end
                end
                hcbd_pkg::PH_AFTER_DATA: begin
                    if (r_in_byte == hcbd_pkg::CH_CR) begin
                        n_phase = hcbd_pkg::PH_SKIP_ONE;
                    end else begin
                        size_line = 1'b1;
                    end
                end
                hcbd_pkg::PH_SKIP_ONE: begin
                    n_phase = hcbd_pkg::PH_LINE_START;
                end
                default: begin
                    n_phase      = hcbd_pkg::PH_LINE_START;
                    n_bytes_left = '0;
                end
            endcase

            if (size_line) begin
                if (hex.is_digit) begin
                    n_bytes_left = sl_bytes;
                    n_phase      = hcbd_pkg::PH_DIGITS;
                end else if (sl_size_zero) begin
                    closes = 1'b1;
                end else begin
                    n_saw_cr = (r_in_byte == hcbd_pkg::CH_CR);
                    n_phase  = hcbd_pkg::PH_EXTENSION;
                end
            end

            if (closes) begin
                res_end  = 1'b1;
                n_closed = 1'b1;
            end else if (r_in_last) begin
                res_end = 1'b1;
                priority if (n_phase == hcbd_pkg::PH_DIGITS) begin
                    res_status = (n_bytes_left == '0) ? hcbd_pkg::ST_ZERO_CHUNK
                                                      : hcbd_pkg::ST_IN_SIZE;
                end else if (n_phase == hcbd_pkg::PH_EXTENSION) begin
                    res_status = hcbd_pkg::ST_IN_SIZE;
                end else begin
                    res_status = hcbd_pkg::ST_IN_DATA;
                end
            end

            // Start the next message afresh
            if (r_in_last) begin
                n_phase      = hcbd_pkg::PH_LINE_START;
                n_bytes_left = '0;
                n_saw_cr     = 1'b0;
                n_closed     = 1'b0;
            end
        end
        res_valid = res_dvalid || res_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_phase      <= hcbd_pkg::PH_LINE_START;
            r_bytes_left <= '0;
            r_saw_cr     <= 1'b0;
            r_closed     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_phase      <= n_phase;
                r_bytes_left <= n_bytes_left;
                r_saw_cr     <= n_saw_cr;
                r_closed     <= n_closed;
                r_out_valid  <= res_valid;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_body_byte;
            r_in_last <= i_body_last;
        end
        if (advance) begin
            r_out_byte   <= res_byte;
            r_out_dvalid <= res_dvalid;
            r_out_end    <= res_end;
            r_out_status <= res_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_data_byte   = r_out_byte;
    assign o_data_valid  = r_out_dvalid;
    assign o_message_end = r_out_end;
    assign o_end_status  = r_out_status;

`ifndef NO_ASSERTIONS
    a_result_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_data_valid || o_message_end))
        else $error("empty result transferred");

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_message_end) |-> (o_end_status == hcbd_pkg::ST_ZERO_CHUNK))
        else $error("end status set without message end");

    a_last_data_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_data_valid && o_message_end)
            |-> (o_end_status == hcbd_pkg::ST_IN_DATA))
        else $error("data byte closing message with wrong status");

    a_data_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hcbd_pkg::PH_DATA) |-> (r_bytes_left != '0))
        else $error("data phase with no bytes left");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_phase == hcbd_pkg::PH_LINE_START && !r_closed
                                    && r_bytes_left == '0))
        else $error("state not reset after last byte");
`endif

endmodule

// ===== bench/hcbd_stream_checker.sv =====
module hcbd_stream_checker #(
    parameter int SIZE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_body_byte,
    input  logic       i_body_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_data_valid,
    input  logic       i_message_end,
    input  logic [1:0] i_end_status,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [SIZE_BITS-1:0] SIZE_ALL_ONES = '1;

    typedef struct {
        logic [7:0]            data_byte;
        logic                  data_valid;
        logic                  message_end;
        hcbd_pkg::t_end_status end_status;
    } t_decoded_out;

    t_decoded_out         awaited_q[$];
    t_decoded_out         head;
    hcbd_pkg::t_phase     phase;
    logic [SIZE_BITS-1:0] chunk_count;
    logic                 cr_seen;
    logic                 msg_closed;
    int                   fail_count = 0;

    function automatic int digit_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    task automatic clear_decode();
        phase       = hcbd_pkg::PH_LINE_START;
        chunk_count = '0;
        cr_seen     = 1'b0;
        msg_closed  = 1'b0;
    endtask

    // One byte of a size line; returns 1 when it closes the message
    function automatic logic absorb_size_char(input logic [7:0] c);
        int d;
        d = digit_of(c);
        if (d >= 0) begin
            if (chunk_count > (SIZE_ALL_ONES >> hcbd_pkg::HEX_DIGIT_BITS)) begin
                chunk_count = SIZE_ALL_ONES;
            end else begin
                chunk_count = (chunk_count << hcbd_pkg::HEX_DIGIT_BITS) + SIZE_BITS'(d);
            end
            phase = hcbd_pkg::PH_DIGITS;
            return 1'b0;
        end
        if (chunk_count == '0) return 1'b1;
        cr_seen = (c == hcbd_pkg::CH_CR);
        phase   = hcbd_pkg::PH_EXTENSION;
        return 1'b0;
    endfunction

    task automatic decode_body_byte(input logic [7:0] c, input logic last);
        t_decoded_out r;
        logic         closes;
        r.data_byte   = '0;
        r.data_valid  = 1'b0;
        r.message_end = 1'b0;
        r.end_status  = hcbd_pkg::ST_ZERO_CHUNK;
        closes        = 1'b0;
        if (msg_closed) begin
            // drop everything up to the last byte
            if (last) clear_decode();
            return;
        end
        case (phase)
            hcbd_pkg::PH_LINE_START, hcbd_pkg::PH_DIGITS: begin
                closes = absorb_size_char(c);
            end
            hcbd_pkg::PH_EXTENSION: begin
                if (c == hcbd_pkg::CH_LF && cr_seen) begin
                    cr_seen = 1'b0;
                    phase   = hcbd_pkg::PH_DATA;
                end else begin
                    cr_seen = (c == hcbd_pkg::CH_CR);
                end
            end
            hcbd_pkg::PH_DATA: begin
                r.data_byte  = c;
                r.data_valid = 1'b1;
                if (chunk_count != '0) chunk_count = chunk_count - SIZE_BITS'(1);
                if (chunk_count == '0) phase = hcbd_pkg::PH_AFTER_DATA;
            end
            hcbd_pkg::PH_AFTER_DATA: begin
                if (c == hcbd_pkg::CH_CR) phase = hcbd_pkg::PH_SKIP_ONE;
                else closes = absorb_size_char(c);
            end
            hcbd_pkg::PH_SKIP_ONE: begin
                phase = hcbd_pkg::PH_LINE_START;
            end
            default: begin
                phase       = hcbd_pkg::PH_LINE_START;
                chunk_count = '0;
            end
        endcase
        if (closes) begin
            r.message_end = 1'b1;
            r.end_status  = hcbd_pkg::ST_ZERO_CHUNK;
            msg_closed    = 1'b1;
        end else if (last) begin
            r.message_end = 1'b1;
            if (phase == hcbd_pkg::PH_DIGITS) begin
                r.end_status = (chunk_count == '0) ? hcbd_pkg::ST_ZERO_CHUNK
                                                   : hcbd_pkg::ST_IN_SIZE;
            end else if (phase == hcbd_pkg::PH_EXTENSION) begin
                r.end_status = hcbd_pkg::ST_IN_SIZE;
            end else begin
                r.end_status = hcbd_pkg::ST_IN_DATA;
            end
        end
        if (last) clear_decode();
        if (r.data_valid || r.message_end) awaited_q.push_back(r);
    endtask

    task automatic note_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_decode();
            awaited_q.delete();
        end else begin
            // a result never belongs to the byte taken at the same edge
            if (i_out_valid && i_out_ready) begin
                if (awaited_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual data_byte=%0h",
                             $time, i_data_byte, " data_valid=%b message_end=%b end_status=%0d",
                             i_data_valid, i_message_end, i_end_status);
                end else begin
                    head = awaited_q.pop_front();
                    if (i_data_byte !== head.data_byte)
                        note_mismatch("data_byte", head.data_byte, i_data_byte);
                    if (i_data_valid !== head.data_valid)
                        note_mismatch("data_valid", 8'(head.data_valid), 8'(i_data_valid));
                    if (i_message_end !== head.message_end)
                        note_mismatch("message_end", 8'(head.message_end), 8'(i_message_end));
                    if (i_end_status !== head.end_status)
                        note_mismatch("end_status", 8'(head.end_status), 8'(i_end_status));
                end
            end
            if (i_in_valid && i_in_ready) decode_body_byte(i_body_byte, i_body_last);
        end
        o_pending    <= awaited_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== bench/http_chunked_body_decoder_test.sv =====
module http_chunked_body_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 1950;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_body_byte  = 8'h00;
    logic       i_body_last  = 1'b0;
    logic       i_out_ready  = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_data_byte;
    logic       o_data_valid;
    logic       o_message_end;
    logic [1:0] o_end_status;

    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         fail_count;
    int         pending_count;
    int         bytes_sent     = 0;
    int         quiet_cycles   = 0;
    logic [7:0] msg_q[$];

    always #5 i_clk = ~i_clk;

    http_chunked_body_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_body_byte   (i_body_byte),
        .i_body_last   (i_body_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_data_byte   (o_data_byte),
        .o_data_valid  (o_data_valid),
        .o_message_end (o_message_end),
        .o_end_status  (o_end_status)
    );

    hcbd_stream_checker result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_body_byte   (i_body_byte),
        .i_body_last   (i_body_last),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_data_byte   (o_data_byte),
        .i_data_valid  (o_data_valid),
        .i_message_end (o_message_end),
        .i_end_status  (o_end_status),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count)
    );

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_body_byte <= b;
        i_body_last <= last;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_q.size(); i++) begin
            push_byte(msg_q[i], i == msg_q.size() - 1);
        end
        msg_q.delete();
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    task automatic put_size(input int unsigned size);
        int top_nib;
        repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0) msg_q.push_back(8'h30);
        top_nib = 7;
        while (top_nib > 0 && ((size >> (4 * top_nib)) & 4'hf) == 0) top_nib--;
        for (int k = top_nib; k >= 0; k--) msg_q.push_back(hex_char(4'(size >> (4 * k))));
    endtask

    task automatic put_line_end();
        if ($urandom_range(9) < 3) begin
            msg_q.push_back(8'h3b);
            repeat ($urandom_range(1, 6)) msg_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
        end
        msg_q.push_back(hcbd_pkg::CH_CR);
        msg_q.push_back(hcbd_pkg::CH_LF);
    endtask

    // Mostly well-formed bodies with random content, then corrupted, cut short and noise
    task automatic build_message();
        int kind;
        int size;
        int cut;
        kind = $urandom_range(99);
        if (kind < 12) begin
            repeat ($urandom_range(1, 12)) msg_q.push_back(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(4)) begin
                size = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
                put_size(size);
                put_line_end();
                repeat (size) msg_q.push_back(8'($urandom_range(255)));
                msg_q.push_back(hcbd_pkg::CH_CR);
                msg_q.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                         : hcbd_pkg::CH_LF);
            end
            put_size(0);
            if ($urandom_range(1)) put_line_end();
            repeat ($urandom_range(2)) msg_q.push_back(8'($urandom_range(255)));
            if (kind < 27) begin
                repeat ($urandom_range(1, 2))
                    msg_q[$urandom_range(msg_q.size() - 1)] = 8'($urandom_range(255));
            end else if (kind < 40) begin
                cut = $urandom_range(1, msg_q.size());
                while (msg_q.size() > cut) void'(msg_q.pop_back());
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // leading CR closes at once, the last byte is dropped
        put_text("\r~");
        send_message();
        // saturating size, cut short in the extension
        put_text("FAfFfFfFf");
        msg_q.push_back(8'hff);
        send_message();
        // a data byte that is also last
        put_text("1\r\n");
        msg_q.push_back(8'h00);
        send_message();
        // zero chunk ended on its digit
        put_text("0");
        send_message();
        // cut short among the size digits
        put_text("a9");
        send_message();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 80;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 80;
                end
                default: begin
                    send_idle_pct  = 37;
                    recv_stall_pct = 37;
                end
            endcase
            while (bytes_sent < (p + 1) * ITEM_TARGET / 4) begin
                build_message();
                send_message();
            end
        end
        i_in_valid <= 1'b0;

        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/hcbd_pkg.sv
src/http_chunked_body_decoder.sv
bench/hcbd_stream_checker.sv
bench/http_chunked_body_decoder_test.sv
